[sv/tmc_pkg.sv]
// tcp_mss_clamp package: field widths, protocol constants and option parser states.
// No dependencies; compile first.
`default_nettype none

package tmc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MSS_W     = 16;
  localparam int unsigned OFS_W     = 8;
  localparam int unsigned CSUM_OFS_W = 7;

  localparam logic [7:0] ETH_TYPE_HI   = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO   = 8'h00;
  localparam logic [7:0] POS_TYPE_HI   = 8'd12;
  localparam logic [7:0] POS_TYPE_LO   = 8'd13;
  localparam logic [7:0] POS_IP_VER    = 8'd14;
  localparam logic [7:0] POS_IP_PROTO  = 8'd23;
  localparam logic [3:0] IP_VERSION4   = 4'd4;
  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
  localparam logic [7:0] TCP_DOFS_OFS  = 8'd12;
  localparam logic [7:0] TCP_FLAGS_OFS = 8'd13;
  localparam logic [7:0] TCP_CSUM_OFS  = 8'd16;
  localparam logic [7:0] TCP_OPT_OFS   = 8'd20;
  localparam logic [5:0] TCP_HDR_MIN   = 6'd20;
  localparam logic [7:0] SYN_BIT       = 8'h02;
  localparam logic [8:0] MIN_FRAME     = 9'd54;

  localparam logic [7:0] OPT_END     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_MSS     = 8'd2;
  localparam logic [7:0] OPT_LEN_MIN = 8'd2;
  localparam logic [7:0] OPT_MSS_LEN = 8'd4;

  typedef enum logic [6:0] {
    PH_KIND      = 7'b0000001,
    PH_LEN_MSS   = 7'b0000010,
    PH_LEN_OTHER = 7'b0000100,
    PH_SKIP      = 7'b0001000,
    PH_MSS_HI    = 7'b0010000,
    PH_MSS_LO    = 7'b0100000,
    PH_DONE      = 7'b1000000
  } opt_phase_t;

endpackage

`default_nettype wire

[sv/tmc_if.sv]
// tcp_mss_clamp channel interfaces: frame byte words in, clamp result words out.
// Depends on tmc_pkg.
`default_nettype none

interface tmc_in_if import tmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last;

  modport source (output valid, frame_byte, last, input ready);
  modport sink   (input valid, frame_byte, last, output ready);
endinterface

interface tmc_out_if import tmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  clamped;
  logic [OFS_W-1:0]      mss_offset;
  logic [MSS_W-1:0]      new_mss;
  logic [CSUM_OFS_W-1:0] checksum_offset;
  logic [MSS_W-1:0]      new_checksum;

  modport source (output valid, clamped, mss_offset, new_mss, checksum_offset, new_checksum,
                  input ready);
  modport sink   (input valid, clamped, mss_offset, new_mss, checksum_offset, new_checksum,
                  output ready);
endinterface

`default_nettype wire

[sv/tcp_mss_clamp.sv]
// TCP MSS clamp checker for IPv4 SYN frames: takes one frame byte per word and
// gives one result word per frame. Frame bytes are accepted one per cycle with no gaps
// needed while the result queue has room; the per-byte parse is a single pass of logic
// into the frame state registers. The result of a frame passes through two registers after
// its last byte: one holds the eligibility verdict and captured fields, the next holds the
// RFC 1624 checksum update. Both result registers are a small queue, so bytes of the next
// frame keep flowing while a result waits. The MSS limit written on mss_limit_we is the
// one in force when the last byte is taken; zero disables clamping.
// Depends on tmc_pkg and tmc_if.
`default_nettype none

module tcp_mss_clamp import tmc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             mss_limit_we,
  input  wire logic [MSS_W-1:0] mss_limit_wdata,
  tmc_in_if.sink                frame,
  tmc_out_if.source             result
);

  logic [MSS_W-1:0] mss_limit;

  logic [7:0]       byte_position, byte_position_next;
  logic             still_eligible, still_eligible_next;
  logic [5:0]       ip_header_bytes, ip_header_bytes_next;
  logic [5:0]       tcp_header_bytes, tcp_header_bytes_next;
  logic [15:0]      old_checksum, old_checksum_next;
  opt_phase_t       option_phase, option_phase_next;
  logic [5:0]       option_skip_count, option_skip_count_next;
  logic [15:0]      old_mss_value, old_mss_value_next;
  logic             mss_found, mss_found_next;
  logic [7:0]       mss_pos, mss_pos_next;

  logic             accept;
  logic             elig_early;
  logic [7:0]       tcp_start, opt_end;
  logic [5:0]       skip_dec;
  logic [8:0]       opt_len_end;
  logic [8:0]       frame_len;
  logic [7:0]       hdr_total;
  logic             frame_ok;

  // verdict stage
  logic             s1_valid, s1_ready;
  logic             s1_ok;
  logic [15:0]      s1_csum, s1_mss, s1_limit;
  logic [7:0]       s1_pos;
  logic [5:0]       s1_ip;

  // result stage
  logic             s2_valid, s2_ready;
  logic [16:0]      sum_a;
  logic [17:0]      sum_b;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign s2_ready    = !s2_valid || result.ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign frame.ready = s1_ready;
  assign accept      = frame.valid && s1_ready;

  assign tcp_start   = ETH_HDR_BYTES + {2'b0, ip_header_bytes};
  assign opt_end     = tcp_start + {2'b0, tcp_header_bytes};
  assign skip_dec    = (option_skip_count != 6'd0) ? option_skip_count - 6'd1 : 6'd0;
  assign opt_len_end = {1'b0, byte_position} - 9'd1 + {1'b0, frame.frame_byte};

  always_comb begin
    byte_position_next     = (byte_position != 8'hFF) ? byte_position + 8'd1 : byte_position;
    still_eligible_next    = still_eligible;
    ip_header_bytes_next   = ip_header_bytes;
    tcp_header_bytes_next  = tcp_header_bytes;
    old_checksum_next      = old_checksum;
    option_phase_next      = option_phase;
    option_skip_count_next = option_skip_count;
    old_mss_value_next     = old_mss_value;
    mss_found_next         = mss_found;
    mss_pos_next           = mss_pos;

    elig_early = still_eligible;
    if (byte_position == POS_TYPE_HI && frame.frame_byte != ETH_TYPE_HI) elig_early = 1'b0;
    if (byte_position == POS_TYPE_LO && frame.frame_byte != ETH_TYPE_LO) elig_early = 1'b0;
    if (byte_position == POS_IP_VER) begin
      if (frame.frame_byte[7:4] != IP_VERSION4 || frame.frame_byte[3:0] < IHL_MIN) begin
        elig_early = 1'b0;
      end else if (still_eligible) begin
        ip_header_bytes_next = {frame.frame_byte[3:0], 2'b00};
      end
    end
    if (byte_position == POS_IP_PROTO && frame.frame_byte != PROTO_TCP) elig_early = 1'b0;
    if (still_eligible) still_eligible_next = elig_early;

    if (still_eligible && elig_early && ip_header_bytes != 6'd0) begin
      if (byte_position == tcp_start + TCP_DOFS_OFS) begin
        if ({frame.frame_byte[7:4], 2'b00} < TCP_HDR_MIN) begin
          still_eligible_next = 1'b0;
        end else begin
          tcp_header_bytes_next = {frame.frame_byte[7:4], 2'b00};
        end
      end
      if (byte_position == tcp_start + TCP_FLAGS_OFS && (frame.frame_byte & SYN_BIT) == 8'd0) begin
        still_eligible_next = 1'b0;
      end
      if (byte_position == tcp_start + TCP_CSUM_OFS) begin
        old_checksum_next[15:8] = frame.frame_byte;
      end
      if (byte_position == tcp_start + TCP_CSUM_OFS + 8'd1) begin
        old_checksum_next[7:0] = frame.frame_byte;
      end
      if (tcp_header_bytes != 6'd0 && byte_position >= tcp_start + TCP_OPT_OFS &&
          byte_position < opt_end) begin
        unique case (option_phase)
          PH_KIND: begin
            if (frame.frame_byte == OPT_END) begin
              option_phase_next = PH_DONE;
            end else if (frame.frame_byte == OPT_NOP) begin
              option_phase_next = PH_KIND;
            end else if ({1'b0, byte_position} + 9'd1 >= {1'b0, opt_end}) begin
              option_phase_next = PH_DONE;
            end else if (frame.frame_byte == OPT_MSS) begin
              option_phase_next = PH_LEN_MSS;
            end else begin
              option_phase_next = PH_LEN_OTHER;
            end
          end
          PH_LEN_MSS, PH_LEN_OTHER: begin
            if (frame.frame_byte < OPT_LEN_MIN || opt_len_end > {1'b0, opt_end}) begin
              option_phase_next = PH_DONE;
            end else if (option_phase == PH_LEN_MSS && frame.frame_byte == OPT_MSS_LEN) begin
              option_phase_next = PH_MSS_HI;
            end else if (frame.frame_byte == OPT_LEN_MIN) begin
              option_phase_next = PH_KIND;
            end else begin
              option_skip_count_next = frame.frame_byte[5:0] - OPT_LEN_MIN[5:0];
              option_phase_next      = PH_SKIP;
            end
          end
          PH_SKIP: begin
            option_skip_count_next = skip_dec;
            if (skip_dec == 6'd0) option_phase_next = PH_KIND;
          end
          PH_MSS_HI: begin
            old_mss_value_next[15:8] = frame.frame_byte;
            mss_pos_next             = byte_position;
            option_phase_next        = PH_MSS_LO;
          end
          PH_MSS_LO: begin
            old_mss_value_next[7:0] = frame.frame_byte;
            mss_found_next          = 1'b1;
            option_phase_next       = PH_DONE;
          end
          PH_DONE: begin
          end
          default: option_phase_next = PH_DONE;
        endcase
      end
    end
  end

  assign frame_len = {1'b0, byte_position} + 9'd1;
  assign hdr_total = ETH_HDR_BYTES + {2'b0, ip_header_bytes_next} + {2'b0, tcp_header_bytes_next};
  assign frame_ok  = still_eligible_next && tcp_header_bytes_next != 6'd0 &&
                     ip_header_bytes_next != 6'd0 && frame_len >= MIN_FRAME &&
                     frame_len >= {1'b0, hdr_total} && mss_found_next &&
                     mss_limit != 16'd0 && old_mss_value_next > mss_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mss_limit <= '0;
    end else if (mss_limit_we) begin
      mss_limit <= mss_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && frame.last)) begin
      byte_position     <= '0;
      still_eligible    <= 1'b1;
      ip_header_bytes   <= '0;
      tcp_header_bytes  <= '0;
      old_checksum      <= '0;
      option_phase      <= PH_KIND;
      option_skip_count <= '0;
      old_mss_value     <= '0;
      mss_found         <= 1'b0;
      mss_pos           <= '0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      still_eligible    <= still_eligible_next;
      ip_header_bytes   <= ip_header_bytes_next;
      tcp_header_bytes  <= tcp_header_bytes_next;
      old_checksum      <= old_checksum_next;
      option_phase      <= option_phase_next;
      option_skip_count <= option_skip_count_next;
      old_mss_value     <= old_mss_value_next;
      mss_found         <= mss_found_next;
      mss_pos           <= mss_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && frame.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && accept && frame.last) begin
      s1_ok    <= frame_ok;
      s1_csum  <= old_checksum_next;
      s1_mss   <= old_mss_value_next;
      s1_limit <= mss_limit;
      s1_pos   <= mss_pos_next;
      s1_ip    <= ip_header_bytes_next;
    end
  end

  // ~(~HC + ~m + m') with end-around carry
  assign sum_a = {1'b0, ~s1_csum} + {1'b0, ~s1_mss};
  assign sum_b = {1'b0, sum_a} + {2'b0, s1_limit};
  assign fold1 = {1'b0, sum_b[15:0]} + {15'b0, sum_b[17:16]};
  assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      result.clamped <= s1_ok;
      if (s1_ok) begin
        result.mss_offset      <= s1_pos;
        result.new_mss         <= s1_limit;
        result.checksum_offset <= CSUM_OFS_W'(ETH_HDR_BYTES + {2'b0, s1_ip} + TCP_CSUM_OFS);
        result.new_checksum    <= ~fold2;
      end else begin
        result.mss_offset      <= '0;
        result.new_mss         <= '0;
        result.checksum_offset <= '0;
        result.new_checksum    <= '0;
      end
    end
  end

  assign result.valid = s2_valid;

`ifndef SYNTHESIS
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ready && frame.last |=> byte_position == 8'd0)
    else $error("frame state not cleared after last word");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !frame.ready |-> s1_valid && s2_valid && !result.ready)
    else $error("input stalled with room in result queue");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    mss_found |-> option_phase == PH_DONE)
    else $error("MSS found but option walk still running");

  a_clamped_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.clamped |-> result.new_mss != 16'd0 &&
    result.checksum_offset != 7'd0 && result.mss_offset > 8'd53)
    else $error("clamped result with bad patch fields");

  a_unclamped_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.clamped |-> result.new_mss == 16'd0 &&
    result.mss_offset == 8'd0 && result.new_checksum == 16'd0)
    else $error("unclamped result with nonzero fields");
`endif

endmodule

`default_nettype wire
